[rtl/core/b64lw_pkg.sv]
// Shared types, character constants and helper functions of the line-wrapped Base64 encoder.
package b64lw_pkg;

  // Character codes
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_PLUS    = 8'h2b;
  localparam logic [7:0] CHAR_SLASH   = 8'h2f;
  localparam logic [7:0] CHAR_PAD     = 8'h3d;
  localparam logic [7:0] CHAR_CR      = 8'h0d;
  localparam logic [7:0] CHAR_LF      = 8'h0a;

  // Line length: 18 groups of four make the usual 72-character line
  localparam int unsigned LineChars     = 72;
  localparam logic [4:0]  DEFAULT_GROUPS = 5'(LineChars / 4);
  localparam logic [4:0]  MIN_GROUPS     = 5'd4;
  localparam logic [4:0]  MAX_GROUPS     = 5'd19;

  // Configuration register indexes
  localparam logic [1:0] REG_LINE_GROUPS = 2'd0;
  localparam logic [1:0] REG_USE_CRLF    = 2'd1;
  localparam logic [1:0] REG_BREAKS_OFF  = 2'd2;

  typedef struct packed {
    logic [4:0] line_groups;
    logic       use_crlf;
    logic       breaks_off;
  } cfg_t;

  // One encoded group handed from the front end to the serializer
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic            eol;
    logic            crlf;
    logic            last;
  } job_t;

  // Map a six-bit value onto the standard alphabet
  function automatic logic [7:0] sym(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = CHAR_UPPER_A + {2'b00, v};
    end else if (v < 6'd52) begin
      r = CHAR_LOWER_A + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      r = CHAR_DIGIT_0 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      r = CHAR_PLUS;
    end else begin
      r = CHAR_SLASH;
    end
    return r;
  endfunction

  // Effective line length in groups; out-of-range settings fall back to the default
  function automatic logic [4:0] line_limit(input logic [4:0] groups);
    logic [4:0] r;
    if (groups < MIN_GROUPS || groups > MAX_GROUPS) begin
      r = DEFAULT_GROUPS;
    end else begin
      r = groups;
    end
    return r;
  endfunction

endpackage

[rtl/core/b64lw_if.sv]
// Stream interfaces: raw byte input channel and encoded character output channel.
interface b64lw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface b64lw_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_last;

  modport source (output valid, output out_char, output out_last, input ready);
  modport sink   (input valid, input out_char, input out_last, output ready);
endinterface

[rtl/core/b64lw_front.sv]
// Front end: collects bytes into groups, encodes them and tracks the line column.
module b64lw_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  b64lw_pkg::cfg_t     cfg_i,
  b64lw_byte_if.sink          in_i,
  input  logic                q_full_i,
  output logic                push_o,
  output b64lw_pkg::job_t     job_o
);

  logic [1:0][7:0] held_q, held_d;
  logic [1:0]      phase_q, phase_d;
  logic [4:0]      col_q, col_d;

  logic       accept;
  logic       fin;
  logic [7:0] b_in;
  logic [4:0] col_inc;
  logic       brk_full;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign fin        = in_i.last;
  assign b_in       = in_i.data_byte;

  // Encode the group and decide on an end of line
  always_comb begin
    held_d   = held_q;
    phase_d  = phase_q;
    col_d    = col_q;
    push_o   = 1'b0;
    job_o    = '0;
    col_inc  = col_q + 5'd1;
    brk_full = 1'b0;
    job_o.crlf = cfg_i.use_crlf;
    job_o.last = fin;

    if (phase_q == 2'd2) begin
      // Full group of three bytes
      job_o.chars[0] = b64lw_pkg::sym(held_q[0][7:2]);
      job_o.chars[1] = b64lw_pkg::sym({held_q[0][1:0], held_q[1][7:4]});
      job_o.chars[2] = b64lw_pkg::sym({held_q[1][3:0], b_in[7:6]});
      job_o.chars[3] = b64lw_pkg::sym(b_in[5:0]);
      if (!cfg_i.breaks_off) begin
        brk_full = col_inc >= b64lw_pkg::line_limit(cfg_i.line_groups);
        col_d    = brk_full ? 5'd0 : col_inc;
      end
      job_o.eol = brk_full || (fin && !cfg_i.breaks_off && col_d != 5'd0);
      push_o    = accept;
      phase_d   = 2'd0;
    end else if (fin) begin
      // Final partial group, padded
      if (phase_q == 2'd1) begin
        job_o.chars[0] = b64lw_pkg::sym(held_q[0][7:2]);
        job_o.chars[1] = b64lw_pkg::sym({held_q[0][1:0], b_in[7:4]});
        job_o.chars[2] = b64lw_pkg::sym({b_in[3:0], 2'b00});
      end else begin
        job_o.chars[0] = b64lw_pkg::sym(b_in[7:2]);
        job_o.chars[1] = b64lw_pkg::sym({b_in[1:0], 4'b0000});
        job_o.chars[2] = b64lw_pkg::CHAR_PAD;
      end
      job_o.chars[3] = b64lw_pkg::CHAR_PAD;
      job_o.eol      = !cfg_i.breaks_off;
      push_o         = accept;
    end else begin
      // Hold the byte until the group fills
      held_d[phase_q[0]] = b_in;
      phase_d            = phase_q + 2'd1;
    end

    // Close the message
    if (fin) begin
      phase_d = 2'd0;
      col_d   = 5'd0;
    end
  end

  // Advance state on an accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
      col_q   <= 5'd0;
    end else if (accept) begin
      phase_q <= phase_d;
      col_q   <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
    end
  end

endmodule

[rtl/core/b64lw_queue.sv]
// Two-entry queue of encoded groups between the front end and the serializer.
module b64lw_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  b64lw_pkg::job_t job_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output b64lw_pkg::job_t head_o
);

  b64lw_pkg::job_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = count_q == 2'd2;
  assign empty_o = count_q == 2'd0;
  assign head_o  = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

[rtl/core/b64lw_back.sv]
// Serializer: emits the characters of each queued group, then its end of line if the group closes a line.
module b64lw_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  b64lw_pkg::job_t head_i,
  output logic            pop_o,
  b64lw_char_if.source    out_o
);

  typedef enum logic [5:0] {
    S_C0 = 6'b000001,
    S_C1 = 6'b000010,
    S_C2 = 6'b000100,
    S_C3 = 6'b001000,
    S_CR = 6'b010000,
    S_LF = 6'b100000
  } step_e;

  step_e      step_q, step_d;
  logic       vld_q, vld_d;
  logic [7:0] char_q, char_d;
  logic       last_q, last_d;
  logic       adv;
  logic       fin_char;
  step_e      step_nxt;
  logic [7:0] sel_char;

  assign out_o.valid    = vld_q;
  assign out_o.out_char = char_q;
  assign out_o.out_last = last_q;

  // Advance when the output register is free or being drained
  assign adv = !vld_q || out_o.ready;

  // Pick the character and the following step
  always_comb begin
    sel_char = head_i.chars[0];
    step_nxt = S_C0;
    fin_char = 1'b0;
    case (step_q)
      S_C0: begin
        sel_char = head_i.chars[0];
        step_nxt = S_C1;
      end
      S_C1: begin
        sel_char = head_i.chars[1];
        step_nxt = S_C2;
      end
      S_C2: begin
        sel_char = head_i.chars[2];
        step_nxt = S_C3;
      end
      S_C3: begin
        sel_char = head_i.chars[3];
        fin_char = !head_i.eol;
        step_nxt = head_i.crlf ? S_CR : S_LF;
      end
      S_CR: begin
        sel_char = b64lw_pkg::CHAR_CR;
        step_nxt = S_LF;
      end
      S_LF: begin
        sel_char = b64lw_pkg::CHAR_LF;
        fin_char = 1'b1;
      end
      default: begin
        sel_char = head_i.chars[0];
        step_nxt = S_C0;
      end
    endcase
  end

  // Load the output register; drop the group after its final character
  always_comb begin
    vld_d  = vld_q;
    char_d = char_q;
    last_d = last_q;
    step_d = step_q;
    pop_o  = 1'b0;
    if (adv) begin
      vld_d = !empty_i;
      if (!empty_i) begin
        char_d = sel_char;
        last_d = head_i.last && fin_char;
        if (fin_char) begin
          pop_o  = 1'b1;
          step_d = S_C0;
        end else begin
          step_d = step_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      step_q <= S_C0;
    end else begin
      vld_q  <= vld_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

endmodule

[rtl/core/base64_encoder_line_wrap.sv]
// Top level of the streaming Base64 encoder with line wrapping.
// Takes one raw byte per transaction and gives one ASCII character per
// transaction (standard alphabet, '=' padding, optional LF or CR LF line ends).
// The input side accepts a byte every cycle while the two-entry group queue
// has room; the output side delivers one character per cycle while the
// receiver is ready and a group is queued, so each three bytes give four
// characters, five or six when a line ends. Sustained throughput is set
// by the single character output register. Configuration writes take
// effect for the next group and should be made between messages.
module base64_encoder_line_wrap (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [4:0] cfg_data_i,
  b64lw_byte_if.sink   in_i,
  b64lw_char_if.source out_o
);

  b64lw_pkg::cfg_t cfg_q;
  b64lw_pkg::job_t push_job;
  b64lw_pkg::job_t head_job;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_groups <= b64lw_pkg::DEFAULT_GROUPS;
      cfg_q.use_crlf    <= 1'b0;
      cfg_q.breaks_off  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        b64lw_pkg::REG_LINE_GROUPS: cfg_q.line_groups <= cfg_data_i;
        b64lw_pkg::REG_USE_CRLF:    cfg_q.use_crlf    <= cfg_data_i[0];
        b64lw_pkg::REG_BREAKS_OFF:  cfg_q.breaks_off  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  b64lw_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .job_o    (push_job)
  );

  b64lw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head_job)
  );

  b64lw_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .head_i  (head_job),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
